FILE: rtl/i2c_master_transfer_engine_macros.svh
// Assertion helpers shared by the checkers of the transfer engine.
`ifndef I2C_MASTER_TRANSFER_ENGINE_MACROS_SVH
`define I2C_MASTER_TRANSFER_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define I2CMTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define I2CMTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/i2cmte_pkg.sv
package i2cmte_pkg;

    // Command codes carried in func
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STRETCH_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT     = 2'd1;
    localparam logic [1:0] CFG_STOP_ENABLE     = 2'd2;
    localparam logic [1:0] CFG_CLEAR_PULSES    = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic       scl_in;
        logic       sda_in;
        logic [7:0] address_byte;
        logic [8:0] length;
        logic       issue_stop;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       tx_taken;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       success;
        logic       busy_res;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_item_t;

endpackage

FILE: rtl/i2cmte_chan_if.sv
interface i2cmte_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/i2c_master_transfer_engine.sv
// I2C master transfer engine, stepped one bus-timing tick per item.
// Channels: in_ch carries one tick (command, sampled SCL/SDA, transfer
// arguments, next write byte); out_ch returns exactly one result item per
// tick (SCL/SDA release levels, tx_taken, rx_valid/rx_byte, done_res/success,
// busy_res). cfg_ch writes the timeout, stop-enable and clear-pulse registers;
// always ready; the user must write it only while no transfer runs (unchecked).
// The result of a tick is presented in the cycle after it is accepted, from
// the output register. One tick per clock while out_ch takes results; the tick
// update is one pass of combinational logic into the state registers.
// While the output register holds an untaken result, in_ch is ready only if
// out_ch takes that result in the same cycle; a stalled receiver therefore
// stalls the tick stream with nothing lost.
// Reset: engine idle, both lines released, registers at their defaults
// (stretch timeout 1000, ack timeout 5000, stop enabled, 18 clear pulses).
module i2c_master_transfer_engine (
    input  logic clk,
    input  logic rst_n,
    i2cmte_chan_if.sink   in_ch,
    i2cmte_chan_if.source out_ch,
    i2cmte_chan_if.sink   cfg_ch
);
    import i2cmte_pkg::*;

    // Phase codes
    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_SA_WAIT   = 5'd1;
    localparam logic [4:0] PH_SA_HOLD   = 5'd2;
    localparam logic [4:0] PH_WB_DATA   = 5'd3;
    localparam logic [4:0] PH_WB_RISE   = 5'd4;
    localparam logic [4:0] PH_WB_WAIT   = 5'd5;
    localparam logic [4:0] PH_WB_END    = 5'd6;
    localparam logic [4:0] PH_WB_REL    = 5'd7;
    localparam logic [4:0] PH_WB_ARISE  = 5'd8;
    localparam logic [4:0] PH_WB_AWAIT  = 5'd9;
    localparam logic [4:0] PH_WB_POLL   = 5'd10;
    localparam logic [4:0] PH_RB_REL    = 5'd11;
    localparam logic [4:0] PH_RB_RISE   = 5'd12;
    localparam logic [4:0] PH_RB_WAIT   = 5'd13;
    localparam logic [4:0] PH_RB_ACK    = 5'd14;
    localparam logic [4:0] PH_RB_ARISE  = 5'd15;
    localparam logic [4:0] PH_RB_AWAIT  = 5'd16;
    localparam logic [4:0] PH_SP_LOW    = 5'd17;
    localparam logic [4:0] PH_SP_RISE   = 5'd18;
    localparam logic [4:0] PH_SP_WAIT   = 5'd19;
    localparam logic [4:0] PH_CL_CHECK  = 5'd20;
    localparam logic [4:0] PH_CL_HIGH   = 5'd21;
    localparam logic [4:0] PH_CL_SAMPLE = 5'd22;

    // Configuration registers
    logic [15:0] stretch_timeout_reg;
    logic [15:0] ack_timeout_reg;
    logic        stop_enable_reg;
    logic [4:0]  clear_pulses_reg;

    // Engine state
    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [8:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic        ok_reg, ok_next;
    logic        read_dir_reg, read_dir_next;
    logic        stop_wanted_reg, stop_wanted_next;
    logic [4:0]  pulse_count_reg, pulse_count_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;

    // Result register
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   res_next;

    in_item_t    tick;
    logic        accept;
    logic        st_timeout;
    logic        do_after;
    logic        do_finish;
    logic        finish_result;
    logic [2:0]  bit_sel;

    assign tick   = in_ch.data;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
    assign cfg_ch.ready = 1'b1;

    // Stretch wait gives up once the low samples reach the limit
    assign st_timeout = wait_count_reg >= stretch_timeout_reg;
    assign bit_sel    = bit_index_reg[2:0];

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        bytes_left_next  = bytes_left_reg;
        wait_count_next  = wait_count_reg;
        ok_next          = ok_reg;
        read_dir_next    = read_dir_reg;
        stop_wanted_next = stop_wanted_reg;
        pulse_count_next = pulse_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        res_next         = '0;
        do_after         = 1'b0;
        do_finish        = 1'b0;
        finish_result    = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (tick.func == FUNC_BEGIN)
                begin
                    read_dir_next    = tick.address_byte[0];
                    stop_wanted_next = tick.issue_stop;
                    bytes_left_next  = tick.length;
                    shift_next       = tick.address_byte;
                    bit_index_next   = '0;
                    ok_next          = 1'b1;
                    wait_count_next  = '0;
                    scl_next         = 1'b1;
                    sda_next         = 1'b1;
                    phase_next       = PH_SA_WAIT;
                end
                else if (tick.func == FUNC_CLEAR)
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_CL_CHECK;
                end
            end
            PH_SA_WAIT:
            begin
                if (tick.scl_in)
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_SA_HOLD;
                end
                else if (st_timeout)
                begin
                    ok_next    = 1'b0;
                    phase_next = PH_SA_HOLD;
                end
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            PH_SA_HOLD:
            begin
                scl_next   = 1'b0;
                phase_next = PH_WB_DATA;
            end
            PH_WB_DATA:
            begin
                sda_next   = shift_reg[3'd7 - bit_sel];
                phase_next = PH_WB_RISE;
            end
            PH_WB_RISE:
            begin
                scl_next        = 1'b1;
                wait_count_next = '0;
                phase_next      = PH_WB_WAIT;
            end
            PH_WB_WAIT:
            begin
                if (tick.scl_in)
                begin
                    bit_index_next = bit_index_reg + 4'd1;
                    if (bit_index_next < 4'd8)
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_WB_DATA;
                    end
                    else
                        phase_next = PH_WB_END;
                end
                else if (st_timeout)
                begin
                    ok_next    = 1'b0;
                    phase_next = PH_WB_END;
                end
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            PH_WB_END:
            begin
                scl_next   = 1'b0;
                phase_next = PH_WB_REL;
            end
            PH_WB_REL:
            begin
                sda_next   = 1'b1;
                phase_next = PH_WB_ARISE;
            end
            PH_WB_ARISE:
            begin
                scl_next        = 1'b1;
                wait_count_next = '0;
                phase_next      = PH_WB_AWAIT;
            end
            PH_WB_AWAIT:
            begin
                if (tick.scl_in || st_timeout)
                begin
                    if (!tick.scl_in)
                        ok_next = 1'b0;
                    wait_count_next = '0;
                    phase_next      = PH_WB_POLL;
                end
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            PH_WB_POLL:
            begin
                if (!tick.sda_in)
                begin
                    scl_next = 1'b0;
                    do_after = 1'b1;
                end
                else if (wait_count_reg >= ack_timeout_reg)
                begin
                    // No ACK within the poll limit
                    ok_next  = 1'b0;
                    scl_next = 1'b0;
                    do_after = 1'b1;
                end
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            PH_RB_REL:
            begin
                sda_next   = 1'b1;
                phase_next = PH_RB_RISE;
            end
            PH_RB_RISE:
            begin
                scl_next        = 1'b1;
                wait_count_next = '0;
                phase_next      = PH_RB_WAIT;
            end
            PH_RB_WAIT:
            begin
                if (tick.scl_in)
                begin
                    if (tick.sda_in)
                        shift_next = shift_reg | (8'h80 >> bit_sel);
                    bit_index_next = bit_index_reg + 4'd1;
                    scl_next       = 1'b0;
                    phase_next     = (bit_index_next >= 4'd8) ? PH_RB_ACK : PH_RB_RISE;
                end
                else if (st_timeout)
                begin
                    ok_next    = 1'b0;
                    scl_next   = 1'b0;
                    phase_next = PH_RB_ACK;
                end
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            PH_RB_ACK:
            begin
                // ACK every byte but the last
                sda_next          = (bytes_left_reg == 9'd0);
                res_next.rx_valid = 1'b1;
                res_next.rx_byte  = shift_reg;
                phase_next        = PH_RB_ARISE;
            end
            PH_RB_ARISE:
            begin
                scl_next        = 1'b1;
                wait_count_next = '0;
                phase_next      = PH_RB_AWAIT;
            end
            PH_RB_AWAIT:
            begin
                if (tick.scl_in || st_timeout)
                begin
                    if (!tick.scl_in)
                        ok_next = 1'b0;
                    scl_next = 1'b0;
                    do_after = 1'b1;
                end
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            PH_SP_LOW:
            begin
                sda_next   = 1'b0;
                phase_next = PH_SP_RISE;
            end
            PH_SP_RISE:
            begin
                scl_next        = 1'b1;
                wait_count_next = '0;
                phase_next      = PH_SP_WAIT;
            end
            PH_SP_WAIT:
            begin
                if (tick.scl_in)
                begin
                    sda_next      = 1'b1;
                    do_finish     = 1'b1;
                    finish_result = ok_reg;
                end
                else if (st_timeout)
                begin
                    // SDA stays low on a STOP timeout
                    ok_next   = 1'b0;
                    do_finish = 1'b1;
                end
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            PH_CL_CHECK:
            begin
                if (tick.sda_in && tick.scl_in)
                begin
                    ok_next       = 1'b1;
                    do_finish     = 1'b1;
                    finish_result = 1'b1;
                end
                else if (tick.scl_in)
                begin
                    pulse_count_next = '0;
                    scl_next         = 1'b0;
                    phase_next       = PH_CL_HIGH;
                end
                else
                begin
                    ok_next   = 1'b0;
                    do_finish = 1'b1;
                end
            end
            PH_CL_HIGH:
            begin
                scl_next   = 1'b1;
                phase_next = PH_CL_SAMPLE;
            end
            PH_CL_SAMPLE:
            begin
                pulse_count_next = pulse_count_reg + 5'd1;
                if (tick.sda_in)
                begin
                    ok_next       = 1'b1;
                    do_finish     = 1'b1;
                    finish_result = 1'b1;
                end
                else if (pulse_count_next >= clear_pulses_reg)
                begin
                    ok_next   = 1'b0;
                    do_finish = 1'b1;
                end
                else
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_CL_HIGH;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // End of a byte: start the next one, or wind the transfer down
        if (do_after)
        begin
            if (ok_next && (bytes_left_reg != 9'd0))
            begin
                bytes_left_next = bytes_left_reg - 9'd1;
                bit_index_next  = '0;
                if (read_dir_reg)
                begin
                    shift_next = '0;
                    phase_next = PH_RB_REL;
                end
                else
                begin
                    shift_next        = tick.tx_byte;
                    res_next.tx_taken = 1'b1;
                    phase_next        = PH_WB_DATA;
                end
            end
            else if ((stop_wanted_reg || !ok_next) && stop_enable_reg)
                phase_next = PH_SP_LOW;
            else
            begin
                do_finish     = 1'b1;
                finish_result = ok_next;
            end
        end

        if (do_finish)
        begin
            res_next.done_res = 1'b1;
            res_next.success  = finish_result;
            phase_next        = PH_IDLE;
        end

        res_next.scl_release = scl_next;
        res_next.sda_release = sda_next;
        res_next.busy_res    = (phase_next != PH_IDLE);
    end

    // Advance engine state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= '0;
            shift_reg       <= '0;
            bytes_left_reg  <= '0;
            wait_count_reg  <= '0;
            ok_reg          <= 1'b1;
            read_dir_reg    <= 1'b0;
            stop_wanted_reg <= 1'b0;
            pulse_count_reg <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            shift_reg       <= shift_next;
            bytes_left_reg  <= bytes_left_next;
            wait_count_reg  <= wait_count_next;
            ok_reg          <= ok_next;
            read_dir_reg    <= read_dir_next;
            stop_wanted_reg <= stop_wanted_next;
            pulse_count_reg <= pulse_count_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
        end
    end

    // Hold the result until taken; load a new one on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= res_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stretch_timeout_reg <= 16'd1000;
            ack_timeout_reg     <= 16'd5000;
            stop_enable_reg     <= 1'b1;
            clear_pulses_reg    <= 5'd18;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.data.index)
                CFG_STRETCH_TIMEOUT: stretch_timeout_reg <= cfg_ch.data.data;
                CFG_ACK_TIMEOUT:     ack_timeout_reg     <= cfg_ch.data.data;
                CFG_STOP_ENABLE:     stop_enable_reg     <= cfg_ch.data.data[0];
                CFG_CLEAR_PULSES:    clear_pulses_reg    <= cfg_ch.data.data[4:0];
                default:             stop_enable_reg     <= stop_enable_reg;
            endcase
        end
    end

endmodule

FILE: rtl/i2cmte_checker.sv
`include "i2c_master_transfer_engine_macros.svh"

module i2cmte_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input i2cmte_pkg::out_item_t out_data
);
    import i2cmte_pkg::*;

    // A stalled result keeps its payload
    `I2CMTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // Every accepted tick shows a result on the next cycle
    `I2CMTE_ASSERT_NEXT(a_tick_result, clk, rst_n, in_valid && in_ready, out_valid, "accepted tick gave no result")

    // A finished operation leaves the engine idle
    `I2CMTE_ASSERT_NOW(a_done_idle, clk, rst_n, out_valid && out_data.done_res, !out_data.busy_res, "done while still busy")

    // Success and received data only appear with their strobes
    `I2CMTE_ASSERT_NOW(a_strobes, clk, rst_n, out_valid, (out_data.done_res || !out_data.success) && (out_data.rx_valid || out_data.rx_byte == 8'd0) && !(out_data.tx_taken && out_data.rx_valid), "result flags inconsistent")

endmodule

bind i2c_master_transfer_engine i2cmte_checker u_i2cmte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
